// File: rtl/irpd_pkg.sv
// Package for the pulse-distance infrared frame decoder.
// Holds widths, register indexes and reset values, the classification record
// and the decoder phase type. Depends on nothing.
`default_nettype none

package irpd_pkg;

    localparam int DUR_W            = 16;
    localparam int ADDR_W           = 16;
    localparam int DATA_W           = 32;
    localparam int SHIFT_W          = ADDR_W + DATA_W;
    localparam int CFG_IDX_W        = 8;
    localparam int NUM_REGS         = 8;

    localparam int FRAME_BITS_DEF     = 48;
    localparam int MIN_MARK_TICKS_DEF = 3;
    localparam int QUEUE_DEPTH_DEF    = 4;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK_MIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_MARK_MAX  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE_MIN = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_SPACE_MAX = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MIN = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE_MAX = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE_MIN = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE_MAX = 8'd7;

    // Reset values: 50 us ticks, 25 percent tolerance, 100 us mark excess.
    localparam logic [DUR_W-1:0] RST_HDR_MARK_MIN   = 16'd67;
    localparam logic [DUR_W-1:0] RST_HDR_MARK_MAX   = 16'd113;
    localparam logic [DUR_W-1:0] RST_HDR_SPACE_MIN  = 16'd67;
    localparam logic [DUR_W-1:0] RST_HDR_SPACE_MAX  = 16'd113;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE_MIN  = 16'd22;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE_MAX  = 16'd38;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE_MIN = 16'd6;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE_MAX = 16'd11;

    // Classification of one duration, computed by the front end.
    typedef struct packed {
        logic start;
        logic last;
        logic hdr_mark_ok;
        logic hdr_space_ok;
        logic mark_ok;
        logic one_ok;
        logic zero_ok;
    } t_cls;

    typedef enum logic [5:0] {
        PH_IDLE      = 6'b000001,
        PH_HDR_MARK  = 6'b000010,
        PH_HDR_SPACE = 6'b000100,
        PH_BIT_MARK  = 6'b001000,
        PH_BIT_SPACE = 6'b010000,
        PH_DONE      = 6'b100000
    } t_phase;

endpackage

`default_nettype wire

// File: rtl/irpd_front.sv
// Front end of the infrared frame decoder: window registers and classifier.
// Turns each duration into a t_cls record. Depends on irpd_pkg.
`default_nettype none

module irpd_front #(
    parameter int MIN_MARK_TICKS = irpd_pkg::MIN_MARK_TICKS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    input  wire logic [irpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [irpd_pkg::DUR_W-1:0]     i_cfg_data,
    input  wire logic [irpd_pkg::DUR_W-1:0]     i_duration,
    input  wire logic                           i_start,
    input  wire logic                           i_last,
    output irpd_pkg::t_cls                      o_cls
);

    localparam logic [irpd_pkg::DUR_W-1:0] MIN_MARK = irpd_pkg::DUR_W'(MIN_MARK_TICKS);

    logic [irpd_pkg::DUR_W-1:0] r_hm_min, r_hm_max, r_hs_min, r_hs_max;
    logic [irpd_pkg::DUR_W-1:0] r_one_min, r_one_max, r_zero_min, r_zero_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hm_min   <= irpd_pkg::RST_HDR_MARK_MIN;
            r_hm_max   <= irpd_pkg::RST_HDR_MARK_MAX;
            r_hs_min   <= irpd_pkg::RST_HDR_SPACE_MIN;
            r_hs_max   <= irpd_pkg::RST_HDR_SPACE_MAX;
            r_one_min  <= irpd_pkg::RST_ONE_SPACE_MIN;
            r_one_max  <= irpd_pkg::RST_ONE_SPACE_MAX;
            r_zero_min <= irpd_pkg::RST_ZERO_SPACE_MIN;
            r_zero_max <= irpd_pkg::RST_ZERO_SPACE_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                irpd_pkg::REG_HDR_MARK_MIN:   r_hm_min   <= i_cfg_data;
                irpd_pkg::REG_HDR_MARK_MAX:   r_hm_max   <= i_cfg_data;
                irpd_pkg::REG_HDR_SPACE_MIN:  r_hs_min   <= i_cfg_data;
                irpd_pkg::REG_HDR_SPACE_MAX:  r_hs_max   <= i_cfg_data;
                irpd_pkg::REG_ONE_SPACE_MIN:  r_one_min  <= i_cfg_data;
                irpd_pkg::REG_ONE_SPACE_MAX:  r_one_max  <= i_cfg_data;
                irpd_pkg::REG_ZERO_SPACE_MIN: r_zero_min <= i_cfg_data;
                irpd_pkg::REG_ZERO_SPACE_MAX: r_zero_max <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cls.start        = i_start;
        o_cls.last         = i_last;
        o_cls.hdr_mark_ok  = (i_duration >= r_hm_min) && (i_duration <= r_hm_max);
        o_cls.hdr_space_ok = (i_duration >= r_hs_min) && (i_duration <= r_hs_max);
        o_cls.mark_ok      = (i_duration >= MIN_MARK);
        o_cls.one_ok       = (i_duration >= r_one_min) && (i_duration <= r_one_max);
        o_cls.zero_ok      = (i_duration >= r_zero_min) && (i_duration <= r_zero_max);
    end

endmodule

`default_nettype wire

// File: rtl/irpd_queue.sv
// Short queue of classification records between front end and decoder.
// Register-based FIFO with simultaneous push and pop. Depends on irpd_pkg.
`default_nettype none

module irpd_queue #(
    parameter int DEPTH = irpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire irpd_pkg::t_cls i_data,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output irpd_pkg::t_cls o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

    irpd_pkg::t_cls   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == DEPTH_C);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_P) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_P) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("queue count exceeds depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not grow on push");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_pop && !do_push) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count did not shrink on pop");

endmodule

`default_nettype wire

// File: rtl/irpd_back.sv
// Back end of the infrared frame decoder: phase machine, bit shifter and
// result register. Consumes t_cls records from the queue. Depends on irpd_pkg.
`default_nettype none

module irpd_back #(
    parameter int FRAME_BITS = irpd_pkg::FRAME_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_q_valid,
    input  wire irpd_pkg::t_cls              i_q_data,
    output logic                             o_q_pop,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic                             o_ok,
    output logic [irpd_pkg::ADDR_W-1:0]      o_address,
    output logic [irpd_pkg::DATA_W-1:0]      o_data
);

    localparam int CW = $clog2(FRAME_BITS + 1);
    localparam logic [CW-1:0] LAST_COUNT = CW'(FRAME_BITS);
    localparam int SW = irpd_pkg::SHIFT_W;

    irpd_pkg::t_phase r_phase, n_phase;
    logic [CW-1:0]    r_count, n_count;
    logic [SW-1:0]    r_shift, n_shift;
    logic             r_out_valid, r_out_ok;
    logic [irpd_pkg::ADDR_W-1:0] r_out_addr;
    logic [irpd_pkg::DATA_W-1:0] r_out_data;
    logic             emit, emit_ok, pop;

    // A record is taken whenever the result register is free or being drained,
    // since any record may produce a result.
    assign pop     = i_q_valid && (!r_out_valid || i_ready);
    assign o_q_pop = pop;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_shift = r_shift;
        emit    = 1'b0;
        emit_ok = 1'b0;
        if (pop) begin
            if (i_q_data.start) begin
                n_phase = irpd_pkg::PH_HDR_MARK;
                n_count = '0;
                n_shift = '0;
                emit    = i_q_data.last;
            end else begin
                unique case (r_phase)
                    irpd_pkg::PH_HDR_MARK: begin
                        if (!i_q_data.hdr_mark_ok) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = irpd_pkg::PH_HDR_SPACE;
                            emit    = i_q_data.last;
                        end
                    end
                    irpd_pkg::PH_HDR_SPACE: begin
                        if (!i_q_data.hdr_space_ok) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = irpd_pkg::PH_BIT_MARK;
                            emit    = i_q_data.last;
                        end
                    end
                    irpd_pkg::PH_BIT_MARK: begin
                        if (!i_q_data.mark_ok) begin
                            emit = 1'b1;
                        end else begin
                            n_phase = irpd_pkg::PH_BIT_SPACE;
                            emit    = i_q_data.last;
                        end
                    end
                    irpd_pkg::PH_BIT_SPACE: begin
                        // The one window is tested before the zero window.
                        if (!i_q_data.one_ok && !i_q_data.zero_ok) begin
                            emit = 1'b1;
                        end else begin
                            n_shift = {r_shift[SW-2:0], i_q_data.one_ok};
                            n_count = r_count + 1'b1;
                            if (n_count == LAST_COUNT) begin
                                emit    = 1'b1;
                                emit_ok = 1'b1;
                            end else begin
                                n_phase = irpd_pkg::PH_BIT_MARK;
                                emit    = i_q_data.last;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (emit) begin
                n_phase = irpd_pkg::PH_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= irpd_pkg::PH_IDLE;
            r_count     <= '0;
            r_shift     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_shift <= n_shift;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_ok   <= emit_ok;
            r_out_addr <= emit_ok ? n_shift[SW-1:irpd_pkg::DATA_W] : '0;
            r_out_data <= emit_ok ? n_shift[irpd_pkg::DATA_W-1:0] : '0;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_ok      = r_out_ok;
    assign o_address = r_out_addr;
    assign o_data    = r_out_data;

    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_phase == irpd_pkg::PH_DONE))
        else $error("phase not finished after a result");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_addr == '0 && r_out_data == '0))
        else $error("failure result carries nonzero payload");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !pop)
        else $error("record taken while result is stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LAST_COUNT)
        else $error("bit count beyond frame length");

endmodule

`default_nettype wire

// File: rtl/ir_pulse_distance_frame_decoder_core.sv
// An accepted duration is registered in the record queue, and its result in the result register that drives m_tvalid.
// Throughput: one duration per cycle while the record queue is not full; the decoder takes
// one queued record per cycle while its result register is free or being drained.
// Reset: synchronous, active low; window registers return to defaults, phase to idle.
// Top level: front-end classifier, record queue and decoder back end.
// Depends on irpd_pkg, irpd_front, irpd_queue and irpd_back.
`default_nettype none

module ir_pulse_distance_frame_decoder_core #(
    parameter int FRAME_BITS     = irpd_pkg::FRAME_BITS_DEF,
    parameter int MIN_MARK_TICKS = irpd_pkg::MIN_MARK_TICKS_DEF,
    parameter int QUEUE_DEPTH    = irpd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [irpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [irpd_pkg::DUR_W-1:0]     i_cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,  // [15:0] duration_ticks
    input  wire logic                           s_tuser,  // [0] capture_start
    input  wire logic                           s_tlast,  // capture_end
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [47:0]                         m_tdata,  // [15:0] frame_address, [47:16] frame_data
    output logic                                m_tuser   // [0] frame_ok
);

    irpd_pkg::t_cls front_cls, q_cls;
    logic           q_full, q_valid, q_pop;
    logic [irpd_pkg::ADDR_W-1:0] frame_address;
    logic [irpd_pkg::DATA_W-1:0] frame_data;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = !q_full;

    irpd_front #(
        .MIN_MARK_TICKS(MIN_MARK_TICKS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_duration (s_tdata),
        .i_start    (s_tuser),
        .i_last     (s_tlast),
        .o_cls      (front_cls)
    );

    irpd_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (s_tvalid),
        .i_data (front_cls),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_cls)
    );

    irpd_back #(
        .FRAME_BITS(FRAME_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .i_q_data (q_cls),
        .o_q_pop  (q_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_ok     (m_tuser),
        .o_address(frame_address),
        .o_data   (frame_data)
    );

    assign m_tdata = {frame_data, frame_address};

endmodule

`default_nettype wire

// File: dv/ir_pulse_distance_frame_decoder_core_tb.sv
// Self-checking testbench for the pulse-distance infrared frame decoder core.
// Drives captured durations and window register writes, predicts each frame result.
// Depends on irpd_pkg and ir_pulse_distance_frame_decoder_core.
`default_nettype none

module ir_pulse_distance_frame_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DUR_W      = irpd_pkg::DUR_W;
    localparam int ADDR_W     = irpd_pkg::ADDR_W;
    localparam int DATA_W     = irpd_pkg::DATA_W;
    localparam int SHIFT_W    = irpd_pkg::SHIFT_W;
    localparam int CFG_IDX_W  = irpd_pkg::CFG_IDX_W;
    localparam int NUM_REGS   = irpd_pkg::NUM_REGS;
    localparam int REG_W      = $clog2(NUM_REGS);
    localparam int FRAME_BITS = irpd_pkg::FRAME_BITS_DEF;
    localparam int MIN_MARK   = irpd_pkg::MIN_MARK_TICKS_DEF;
    localparam int SETTLE     = 2 * irpd_pkg::QUEUE_DEPTH_DEF + 8;
    localparam int MAX_CYCLES = 600000;
    localparam int N_DUR      = 2 + 2 * FRAME_BITS;  // durations after the start item
    localparam logic [DUR_W-1:0] DUR_MAX = '1;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_frame;

    typedef enum int {WIN_WIDE, WIN_TIGHT, WIN_RANDOM} t_win_set;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [DUR_W-1:0]     i_cfg_data  = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata     = '0;
    logic                 s_tuser     = 1'b0;
    logic                 s_tlast     = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [47:0]          m_tdata;
    logic                 m_tuser;

    // Decoder state as predicted from the accepted durations.
    irpd_pkg::t_phase     dec_phase = irpd_pkg::PH_IDLE;
    int unsigned          nbits     = 0;
    logic [SHIFT_W-1:0]   shreg     = '0;
    logic [DUR_W-1:0]     win [NUM_REGS];
    t_frame               frame_q [$];

    int unsigned          n_items   = 0;
    int unsigned          n_frames  = 0;
    int unsigned          n_err     = 0;
    int unsigned          n_cycles  = 0;
    int unsigned          tx_idle_pct = 0;
    int unsigned          rx_idle_pct = 0;

    ir_pulse_distance_frame_decoder_core #(
        .FRAME_BITS    (FRAME_BITS),
        .MIN_MARK_TICKS(MIN_MARK),
        .QUEUE_DEPTH   (irpd_pkg::QUEUE_DEPTH_DEF)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= MAX_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Frame result checker.
    always @(posedge i_clk) begin
        t_frame exp_f;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (frame_q.size() == 0) begin
                $display("%0t: unexpected frame result ok=%0b tdata=%h", $time, m_tuser, m_tdata);
                n_err++;
            end else begin
                exp_f = frame_q.pop_front();
                if (m_tuser !== exp_f.ok) begin
                    $display("%0t: frame_ok expected %0b actual %0b", $time, exp_f.ok, m_tuser);
                    n_err++;
                end
                if (m_tdata[ADDR_W-1:0] !== exp_f.addr) begin
                    $display("%0t: frame_address expected %h actual %h",
                             $time, exp_f.addr, m_tdata[ADDR_W-1:0]);
                    n_err++;
                end
                if (m_tdata[SHIFT_W-1:ADDR_W] !== exp_f.data) begin
                    $display("%0t: frame_data expected %h actual %h",
                             $time, exp_f.data, m_tdata[SHIFT_W-1:ADDR_W]);
                    n_err++;
                end
            end
        end
    end

    function automatic logic [DUR_W-1:0] win_of(input logic [CFG_IDX_W-1:0] idx);
        return win[idx[REG_W-1:0]];
    endfunction

    function automatic void set_win(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DUR_W-1:0] val);
        win[idx[REG_W-1:0]] = val;
    endfunction

    function automatic bit in_win(input logic [DUR_W-1:0] d, lo, hi);
        return d >= lo && d <= hi;
    endfunction

    function automatic void post_frame(input bit ok);
        t_frame f;
        f.ok   = ok;
        f.addr = ok ? shreg[SHIFT_W-1:DATA_W] : '0;
        f.data = ok ? shreg[DATA_W-1:0] : '0;
        frame_q.push_back(f);
        n_frames++;
        dec_phase = irpd_pkg::PH_DONE;
    endfunction

    // Advances the predicted decoder by one duration. Returns 1 unless the
    // duration is ignored because no capture is in progress.
    function automatic bit decode_duration(input logic [DUR_W-1:0] d, input bit start, fin);
        bit busy;
        busy = start || (dec_phase != irpd_pkg::PH_IDLE && dec_phase != irpd_pkg::PH_DONE);
        if (start) begin
            dec_phase = irpd_pkg::PH_HDR_MARK;
            nbits     = 0;
            shreg     = '0;
            if (fin)
                post_frame(1'b0);
            return busy;
        end
        case (dec_phase)
            irpd_pkg::PH_HDR_MARK: begin
                if (!in_win(d, win_of(irpd_pkg::REG_HDR_MARK_MIN),
                            win_of(irpd_pkg::REG_HDR_MARK_MAX))) begin
                    post_frame(1'b0);
                    return busy;
                end
                dec_phase = irpd_pkg::PH_HDR_SPACE;
            end
            irpd_pkg::PH_HDR_SPACE: begin
                if (!in_win(d, win_of(irpd_pkg::REG_HDR_SPACE_MIN),
                            win_of(irpd_pkg::REG_HDR_SPACE_MAX))) begin
                    post_frame(1'b0);
                    return busy;
                end
                dec_phase = irpd_pkg::PH_BIT_MARK;
            end
            irpd_pkg::PH_BIT_MARK: begin
                if (d < MIN_MARK) begin
                    post_frame(1'b0);
                    return busy;
                end
                dec_phase = irpd_pkg::PH_BIT_SPACE;
            end
            irpd_pkg::PH_BIT_SPACE: begin
                // The one window wins where the two windows overlap.
                if (in_win(d, win_of(irpd_pkg::REG_ONE_SPACE_MIN),
                           win_of(irpd_pkg::REG_ONE_SPACE_MAX)))
                    shreg = {shreg[SHIFT_W-2:0], 1'b1};
                else if (in_win(d, win_of(irpd_pkg::REG_ZERO_SPACE_MIN),
                                win_of(irpd_pkg::REG_ZERO_SPACE_MAX)))
                    shreg = {shreg[SHIFT_W-2:0], 1'b0};
                else begin
                    post_frame(1'b0);
                    return busy;
                end
                nbits++;
                if (nbits >= FRAME_BITS) begin
                    post_frame(1'b1);
                    return busy;
                end
                dec_phase = irpd_pkg::PH_BIT_MARK;
            end
            default: return busy;
        endcase
        if (fin)
            post_frame(1'b0);
        return busy;
    endfunction

    function automatic logic [DUR_W-1:0] pick_inside(input logic [DUR_W-1:0] lo, hi);
        if (lo > hi)
            return DUR_W'($urandom());
        return DUR_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [DUR_W-1:0] pick_outside(input logic [DUR_W-1:0] lo, hi);
        if (lo > hi)
            return DUR_W'($urandom());
        if (lo != 0 && (hi == DUR_MAX || $urandom_range(1, 0) == 1))
            return DUR_W'($urandom_range(lo - 1, 0));
        if (hi != DUR_MAX)
            return DUR_W'($urandom_range(DUR_MAX, hi + 1));
        return DUR_W'($urandom());
    endfunction

    // Position k counts durations after the start item: header mark, header
    // space, then alternating bit marks and bit spaces.
    function automatic logic [DUR_W-1:0] good_dur(input int k);
        bit one_empty;
        bit zero_empty;
        one_empty  = win_of(irpd_pkg::REG_ONE_SPACE_MIN) > win_of(irpd_pkg::REG_ONE_SPACE_MAX);
        zero_empty = win_of(irpd_pkg::REG_ZERO_SPACE_MIN) > win_of(irpd_pkg::REG_ZERO_SPACE_MAX);
        if (k == 0)
            return pick_inside(win_of(irpd_pkg::REG_HDR_MARK_MIN),
                               win_of(irpd_pkg::REG_HDR_MARK_MAX));
        if (k == 1)
            return pick_inside(win_of(irpd_pkg::REG_HDR_SPACE_MIN),
                               win_of(irpd_pkg::REG_HDR_SPACE_MAX));
        if (k % 2 == 0)
            return ($urandom_range(9, 0) == 0) ? DUR_W'($urandom_range(DUR_MAX, MIN_MARK))
                                               : DUR_W'($urandom_range(20, MIN_MARK));
        if (one_empty || (!zero_empty && $urandom_range(1, 0) == 1))
            return pick_inside(win_of(irpd_pkg::REG_ZERO_SPACE_MIN),
                               win_of(irpd_pkg::REG_ZERO_SPACE_MAX));
        return pick_inside(win_of(irpd_pkg::REG_ONE_SPACE_MIN),
                           win_of(irpd_pkg::REG_ONE_SPACE_MAX));
    endfunction

    function automatic logic [DUR_W-1:0] bad_dur(input int k);
        if (k == 0)
            return pick_outside(win_of(irpd_pkg::REG_HDR_MARK_MIN),
                                win_of(irpd_pkg::REG_HDR_MARK_MAX));
        if (k == 1)
            return pick_outside(win_of(irpd_pkg::REG_HDR_SPACE_MIN),
                                win_of(irpd_pkg::REG_HDR_SPACE_MAX));
        if (k % 2 == 0)
            return DUR_W'($urandom_range(MIN_MARK - 1, 0));
        return pick_outside(win_of(irpd_pkg::REG_ONE_SPACE_MIN),
                            win_of(irpd_pkg::REG_ONE_SPACE_MAX));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction,
    // with s_tvalid still high.
    task automatic send_dur(input logic [DUR_W-1:0] d, input bit start, fin);
        while ($urandom_range(99, 0) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= start;
        s_tlast  <= fin;
        do @(posedge i_clk); while (!s_tready);
        if (decode_duration(d, start, fin))
            n_items++;
        @(negedge i_clk);
    endtask

    // Holds off the sender until every predicted frame has come out and the
    // record queue has had time to empty.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (frame_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Leaves i_cfg_valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_REGS)
            set_win(idx, val);
        @(negedge i_clk);
    endtask

    task automatic load_windows(input t_win_set sel);
        logic [DUR_W-1:0] lo;
        wait_idle();
        case (sel)
            WIN_WIDE: begin
                write_reg(irpd_pkg::REG_HDR_MARK_MIN, '0);
                write_reg(irpd_pkg::REG_HDR_MARK_MAX, DUR_MAX);
                write_reg(irpd_pkg::REG_HDR_SPACE_MIN, '0);
                write_reg(irpd_pkg::REG_HDR_SPACE_MAX, DUR_MAX);
                // Overlapping bit windows: 10 to 20 ticks must decode as one.
                write_reg(irpd_pkg::REG_ONE_SPACE_MIN, '0);
                write_reg(irpd_pkg::REG_ONE_SPACE_MAX, 16'd20);
                write_reg(irpd_pkg::REG_ZERO_SPACE_MIN, 16'd10);
                write_reg(irpd_pkg::REG_ZERO_SPACE_MAX, DUR_MAX);
            end
            WIN_TIGHT: begin
                write_reg(irpd_pkg::REG_HDR_MARK_MIN, DUR_MAX);
                write_reg(irpd_pkg::REG_HDR_MARK_MAX, DUR_MAX);
                write_reg(irpd_pkg::REG_HDR_SPACE_MIN, '0);
                write_reg(irpd_pkg::REG_HDR_SPACE_MAX, '0);
                write_reg(irpd_pkg::REG_ONE_SPACE_MIN, 16'd5);
                write_reg(irpd_pkg::REG_ONE_SPACE_MAX, 16'd9);
                // Empty zero window: only all-ones frames can pass.
                write_reg(irpd_pkg::REG_ZERO_SPACE_MIN, DUR_MAX);
                write_reg(irpd_pkg::REG_ZERO_SPACE_MAX, '0);
            end
            default: begin
                for (int r = 0; r < NUM_REGS; r += 2) begin
                    lo = DUR_W'($urandom_range(300, 0));
                    write_reg(r[CFG_IDX_W-1:0], lo);
                    write_reg(r[CFG_IDX_W-1:0] + 1'b1, lo + DUR_W'($urandom_range(120, 0)));
                end
                // An index past the register file must change nothing.
                write_reg(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, NUM_REGS)),
                          DUR_W'($urandom()));
            end
        endcase
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One capture: about a third are well formed with random bits, the rest break at
    // some point by a window miss, an early end or plain truncation.
    task automatic send_random_frame();
        bit well;
        int cut;
        int how;
        well = ($urandom_range(99, 0) < 35);
        cut  = well ? N_DUR : ($urandom_range(1, 0) ? $urandom_range(5, 0)
                                                     : $urandom_range(N_DUR - 1, 0));
        how  = $urandom_range(2, 0);
        send_dur(DUR_W'($urandom()), 1'b1, $urandom_range(39, 0) == 0);
        for (int k = 0; k < N_DUR; k++) begin
            if (k == cut) begin
                if (how == 0)
                    send_dur(bad_dur(k), 1'b0, $urandom_range(1, 0) == 1);
                else if (how == 1)
                    send_dur(good_dur(k), 1'b0, 1'b1);
                break;
            end
            send_dur(good_dur(k), 1'b0,
                     (k == N_DUR - 1) ? ($urandom_range(1, 0) == 1) : 1'b0);
        end
        repeat ($urandom_range(3, 0))
            send_dur(DUR_W'($urandom()), 1'b0, $urandom_range(1, 0) == 1);
    endtask

    task automatic run_frames(input int unsigned item_goal, frame_goal);
        int unsigned items0;
        int unsigned frames0;
        items0  = n_items;
        frames0 = n_frames;
        while (n_items - items0 < item_goal || n_frames - frames0 < frame_goal) begin
            send_random_frame();
            if ($urandom_range(19, 0) == 0)
                wait_idle();
        end
    endtask

    task automatic test_directed();
        // Nothing happens before the first start item.
        send_dur(DUR_MAX, 1'b0, 1'b1);
        // Start and end on the same item: the capture closes with a failure result.
        send_dur(16'h0000, 1'b1, 1'b1);
        // Header mark below its window; the following item is ignored.
        send_dur(DUR_MAX, 1'b1, 1'b0);
        send_dur(16'h0000, 1'b0, 1'b0);
        send_dur(DUR_MAX, 1'b0, 1'b1);
        // Header mark on its upper edge, header space just above its window.
        send_dur(16'hABCD, 1'b1, 1'b0);
        send_dur(irpd_pkg::RST_HDR_MARK_MAX, 1'b0, 1'b0);
        send_dur(irpd_pkg::RST_HDR_SPACE_MAX + 1'b1, 1'b0, 1'b0);
        // Restart in the middle of the header, then end right after the header.
        send_dur(16'h5432, 1'b1, 1'b0);
        send_dur(irpd_pkg::RST_HDR_MARK_MIN, 1'b0, 1'b0);
        send_dur(16'h0001, 1'b1, 1'b0);
        send_dur(irpd_pkg::RST_HDR_MARK_MIN, 1'b0, 1'b0);
        send_dur(irpd_pkg::RST_HDR_SPACE_MIN, 1'b0, 1'b1);
        // Bit mark one tick short.
        send_dur(16'h0000, 1'b1, 1'b0);
        send_dur(16'd90, 1'b0, 1'b0);
        send_dur(16'd90, 1'b0, 1'b0);
        send_dur(DUR_W'(MIN_MARK - 1), 1'b0, 1'b0);
        // Bit space that falls between the zero and the one windows.
        send_dur(16'h0000, 1'b1, 1'b0);
        send_dur(16'd90, 1'b0, 1'b0);
        send_dur(16'd90, 1'b0, 1'b0);
        send_dur(DUR_W'(MIN_MARK), 1'b0, 1'b0);
        send_dur(irpd_pkg::RST_ZERO_SPACE_MAX + 1'b1, 1'b0, 1'b0);
        // End flag on a passing bit space that is not the last one.
        send_dur(16'h0000, 1'b1, 1'b0);
        send_dur(16'd90, 1'b0, 1'b0);
        send_dur(16'd90, 1'b0, 1'b0);
        send_dur(DUR_MAX, 1'b0, 1'b0);
        send_dur(irpd_pkg::RST_ONE_SPACE_MAX, 1'b0, 1'b0);
        send_dur(DUR_W'(MIN_MARK), 1'b0, 1'b0);
        send_dur(irpd_pkg::RST_ZERO_SPACE_MIN, 1'b0, 1'b1);
    endtask

    task automatic test_default_windows();
        run_frames(310, 12);
    endtask

    task automatic test_wide_windows();
        load_windows(WIN_WIDE);
        run_frames(340, 12);
    endtask

    task automatic test_tight_windows();
        load_windows(WIN_TIGHT);
        run_frames(300, 12);
    endtask

    task automatic test_random_windows();
        for (int n = 0; n < 3; n++) begin
            load_windows(WIN_RANDOM);
            run_frames(115, 5);
        end
    endtask

    initial begin
        set_win(irpd_pkg::REG_HDR_MARK_MIN,   irpd_pkg::RST_HDR_MARK_MIN);
        set_win(irpd_pkg::REG_HDR_MARK_MAX,   irpd_pkg::RST_HDR_MARK_MAX);
        set_win(irpd_pkg::REG_HDR_SPACE_MIN,  irpd_pkg::RST_HDR_SPACE_MIN);
        set_win(irpd_pkg::REG_HDR_SPACE_MAX,  irpd_pkg::RST_HDR_SPACE_MAX);
        set_win(irpd_pkg::REG_ONE_SPACE_MIN,  irpd_pkg::RST_ONE_SPACE_MIN);
        set_win(irpd_pkg::REG_ONE_SPACE_MAX,  irpd_pkg::RST_ONE_SPACE_MAX);
        set_win(irpd_pkg::REG_ZERO_SPACE_MIN, irpd_pkg::RST_ZERO_SPACE_MIN);
        set_win(irpd_pkg::REG_ZERO_SPACE_MAX, irpd_pkg::RST_ZERO_SPACE_MAX);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 20;
        rx_idle_pct = 86;
        test_directed();
        test_default_windows();

        tx_idle_pct = 86;
        rx_idle_pct = 20;
        test_wide_windows();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_tight_windows();
        test_random_windows();

        wait_idle();
        if (n_err == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
